### hw/rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

   localparam int STACK_DEPTH_DEF   = 16;
   localparam int VALUE_WIDTH_DEF   = 48;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int STATUS_W = 3;
   localparam int CHAR_W   = 8;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_LEFTOVER  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_SAT       = 3'd5;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [1:0] {
      KIND_SPACE,
      KIND_OP,
      KIND_NUM
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_RD1,
      S_RD2,
      S_INIT,
      S_EXEC,
      S_END,
      S_FIN
   } state_type;

   typedef struct packed {
      logic load_in;
      logic push_num;
      logic err_under;
      logic rd_top;
      logic rd_second;
      logic ld_r;
      logic ld_l;
      logic op_init;
      logic op_step;
      logic push_res;
      logic finish;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     lt2;
      logic     last;
      logic     op_done;
      logic     rsp_busy;
   } sts_type;

endpackage

### hw/rtl/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Sequencer: walks one character through decode, stack reads, arithmetic
// and push, and issues the result beat on the last character.
// ----------------------------------------------------------------------------
module pse_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  pse_pkg::sts_type sts,
   output pse_pkg::cmd_type cmd
);
   import pse_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (sts.kind == KIND_OP) begin
               if (sts.lt2) begin
                  cmd.err_under = 1'b1;
                  state_in      = S_END;
               end else begin
                  cmd.rd_top = 1'b1;
                  state_in   = S_RD1;
               end
            end else if (sts.kind == KIND_NUM) begin
               cmd.push_num = 1'b1;
               state_in     = S_END;
            end else begin
               state_in = S_END;
            end
         end
         S_RD1: begin
            cmd.ld_r      = 1'b1;
            cmd.rd_second = 1'b1;
            state_in      = S_RD2;
         end
         S_RD2: begin
            cmd.ld_l = 1'b1;
            state_in = S_INIT;
         end
         S_INIT: begin
            cmd.op_init = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            if (sts.op_done) begin
               cmd.push_res = 1'b1;
               state_in     = S_END;
            end else begin
               cmd.op_step = 1'b1;
            end
         end
         S_END: begin
            if (sts.last) begin
               cmd.rd_top = 1'b1;
               state_in   = S_FIN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            if (!sts.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/pse_dp.sv
// ----------------------------------------------------------------------------
// pse_dp
// Datapath: operand stack, saturating add and subtract, shift-add
// multiplier, restoring divider, error tracking and the result register.
// ----------------------------------------------------------------------------
module pse_dp #(
   parameter int STACK_DEPTH   = pse_pkg::STACK_DEPTH_DEF,
   parameter int VALUE_WIDTH   = pse_pkg::VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = pse_pkg::FRACTION_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [pse_pkg::CHAR_W-1:0]   req_tdata,
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [((VALUE_WIDTH+pse_pkg::STATUS_W+7)/8)*8-1:0] rsp_tdata,
   input  pse_pkg::cmd_type             cmd,
   output pse_pkg::sts_type             sts
);
   import pse_pkg::*;

   localparam int W   = VALUE_WIDTH;
   localparam int F   = FRACTION_BITS;
   localparam int NW  = W + F;
   localparam int MW  = 2 * W + F;
   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int SCW = $clog2(NW + 1);
   localparam int TW  = ((W + STATUS_W + 7) / 8) * 8;

   logic [CHAR_W-1:0]   char_ff;
   logic                last_ff;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [STATUS_W-1:0] err_ff, err_in;
   logic [W-1:0]        r_ff, l_ff;
   op_type              op_ff;
   logic                neg_ff, zdiv_ff;
   logic [W-1:0]        opnd_ff;
   logic [2*W-1:0]      prod_ff;
   logic [NW-1:0]       q_ff;
   logic [W-1:0]        rem_ff;
   logic [SCW-1:0]      steps_ff;
   logic                rsp_valid_ff;
   logic [W-1:0]        rsp_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [W-1:0]        ram_rdata;
   logic                ram_we;
   logic [W-1:0]        ram_wdata;
   logic [AW-1:0]       ram_raddr;
   kind_type            kind;
   op_type              op_dec;
   logic                full;

   function automatic logic [W:0] fit(input logic neg, input logic [MW-1:0] m);
      logic [MW-1:0] lim;
      logic [W-1:0]  v;
      logic          sat;
      lim = (MW'(1) << (W - 1)) - {{(MW-1){1'b0}}, ~neg};
      sat = (m > lim);
      if (sat) begin
         v = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         v = neg ? (~m[W-1:0] + {{(W-1){1'b0}}, 1'b1}) : m[W-1:0];
      end
      return {sat, v};
   endfunction

   function automatic logic [W-1:0] absv(input logic [W-1:0] x);
      return x[W-1] ? (~x + {{(W-1){1'b0}}, 1'b1}) : x;
   endfunction

   always_comb begin
      kind   = KIND_NUM;
      op_dec = OP_ADD;
      priority if ((char_ff >= CHAR_TAB && char_ff <= CHAR_CR) || char_ff == CHAR_SPACE) begin
         kind = KIND_SPACE;
      end else if (char_ff == CHAR_PLUS) begin
         kind = KIND_OP;
      end else if (char_ff == CHAR_MINUS) begin
         kind   = KIND_OP;
         op_dec = OP_SUB;
      end else if (char_ff == CHAR_STAR) begin
         kind   = KIND_OP;
         op_dec = OP_MUL;
      end else if (char_ff == CHAR_SLASH) begin
         kind   = KIND_OP;
         op_dec = OP_DIV;
      end else begin
         kind = KIND_NUM;
      end
   end

   assign full = (cnt_ff == CW'(STACK_DEPTH));

   // arithmetic result
   logic [W:0]      sum;
   logic [W:0]      res_fit;
   logic [W-1:0]    res_val;
   logic            res_sat;
   logic [W:0]      num_fit;
   logic [CHAR_W-1:0] num_diff;
   logic            num_neg;

   always_comb begin
      sum     = '0;
      res_fit = '0;
      res_val = '0;
      res_sat = 1'b0;
      unique case (op_ff)
         OP_ADD, OP_SUB: begin
            sum = (op_ff == OP_ADD) ? ({l_ff[W-1], l_ff} + {r_ff[W-1], r_ff})
                                    : ({l_ff[W-1], l_ff} - {r_ff[W-1], r_ff});
            res_sat = (sum[W] != sum[W-1]);
            res_val = res_sat ? (sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                              : sum[W-1:0];
         end
         OP_MUL: begin
            res_fit = fit(neg_ff, MW'(prod_ff >> F));
            res_sat = res_fit[W];
            res_val = res_fit[W-1:0];
         end
         OP_DIV: begin
            res_fit = fit(neg_ff, MW'(q_ff));
            res_sat = res_fit[W] && !zdiv_ff;
            res_val = zdiv_ff ? '0 : res_fit[W-1:0];
         end
         default: begin
            res_val = '0;
         end
      endcase
      num_neg  = (char_ff < CHAR_ZERO);
      num_diff = num_neg ? (CHAR_ZERO - char_ff) : (char_ff - CHAR_ZERO);
      num_fit  = fit(num_neg, MW'(num_diff) << F);
   end

   // error, count and write control
   always_comb begin
      err_in    = err_ff;
      cnt_in    = cnt_ff;
      ram_we    = 1'b0;
      ram_wdata = res_val;
      if (cmd.push_num) begin
         ram_wdata = num_fit[W-1:0];
         if (err_in == STATUS_OK && num_fit[W]) begin
            err_in = STATUS_SAT;
         end
         if (full) begin
            if (err_in == STATUS_OK) begin
               err_in = STATUS_OVERFLOW;
            end
         end else begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + CW'(1);
         end
      end
      if (cmd.err_under && err_in == STATUS_OK) begin
         err_in = STATUS_UNDERFLOW;
      end
      if (cmd.ld_l) begin
         cnt_in = cnt_ff - CW'(2);
      end
      if (cmd.push_res) begin
         if (err_in == STATUS_OK && op_ff == OP_DIV && zdiv_ff) begin
            err_in = STATUS_DIV_ZERO;
         end
         if (err_in == STATUS_OK && res_sat) begin
            err_in = STATUS_SAT;
         end
         ram_we = 1'b1;
         cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.finish) begin
         cnt_in = '0;
         err_in = STATUS_OK;
      end
   end

   assign ram_raddr = cmd.rd_second ? AW'(cnt_ff - CW'(2)) : AW'(cnt_ff - CW'(1));

   pse_ram #(
      .WIDTH (W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd_top | cmd.rd_second),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
         steps_ff     <= '0;
      end else begin
         cnt_ff <= cnt_in;
         err_ff <= err_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.op_init) begin
            unique case (op_ff)
               OP_MUL:  steps_ff <= SCW'(W);
               OP_DIV:  steps_ff <= (absv(r_ff) == '0) ? '0 : SCW'(NW);
               default: steps_ff <= '0;
            endcase
         end else if (cmd.op_step) begin
            steps_ff <= steps_ff - SCW'(1);
         end
      end
   end

   // payload registers
   logic [W:0] trial;
   assign trial = {rem_ff, q_ff[NW-1]};

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      if (cmd.ld_r) begin
         r_ff  <= ram_rdata;
         op_ff <= op_dec;
      end
      if (cmd.ld_l) begin
         l_ff <= ram_rdata;
      end
      if (cmd.op_init) begin
         neg_ff  <= l_ff[W-1] ^ r_ff[W-1];
         zdiv_ff <= (absv(r_ff) == '0);
         opnd_ff <= (op_ff == OP_MUL) ? absv(l_ff) : absv(r_ff);
         prod_ff <= {{W{1'b0}}, absv(r_ff)};
         q_ff    <= NW'(absv(l_ff)) << F;
         rem_ff  <= '0;
      end else if (cmd.op_step) begin
         if (op_ff == OP_MUL) begin
            prod_ff <= prod_ff[0] ? {({1'b0, prod_ff[2*W-1:W]} + {1'b0, opnd_ff}),
                                     prod_ff[W-1:1]}
                                  : {1'b0, prod_ff[2*W-1:W], prod_ff[W-1:1]};
         end else begin
            if (trial >= {1'b0, opnd_ff}) begin
               rem_ff <= W'(trial - {1'b0, opnd_ff});
               q_ff   <= {q_ff[NW-2:0], 1'b1};
            end else begin
               rem_ff <= trial[W-1:0];
               q_ff   <= {q_ff[NW-2:0], 1'b0};
            end
         end
      end
      if (cmd.finish) begin
         rsp_value_ff <= (cnt_ff == '0) ? '0 : ram_rdata;
         priority if (err_ff != STATUS_OK) begin
            rsp_status_ff <= err_ff;
         end else if (cnt_ff == '0) begin
            rsp_status_ff <= STATUS_UNDERFLOW;
         end else if (cnt_ff > CW'(1)) begin
            rsp_status_ff <= STATUS_LEFTOVER;
         end else begin
            rsp_status_ff <= STATUS_OK;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = TW'({rsp_status_ff, rsp_value_ff});
   assign sts.kind     = kind;
   assign sts.lt2      = (cnt_ff < CW'(2));
   assign sts.last     = last_ff;
   assign sts.op_done  = (steps_ff == '0);
   assign sts.rsp_busy = rsp_valid_ff && !rsp_tready;

endmodule

### hw/rtl/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Evaluates a postfix expression streamed one character per beat and
// returns the top of stack with a status code after the last character.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                  | tlast
//  req     | in  | token_char[7:0]                     | end_of_expr
//  rsp     | out | value[W-1:0], status[2:0], zero pad | -
//
//  + and - use the saturating adder, * a shift-add multiplier (one bit a cycle),
//  / a restoring divider (one bit a cycle); whitespace and digits skip the arithmetic.
//  The last character also reads the top of stack and loads the result register.
//  Reset clears the stack count, the error code and the result valid.
//  A result waiting on rsp_tready holds only the next last character.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
   parameter int STACK_DEPTH   = pse_pkg::STACK_DEPTH_DEF,
   parameter int VALUE_WIDTH   = pse_pkg::VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = pse_pkg::FRACTION_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [pse_pkg::CHAR_W-1:0] req_tdata,   // token_char
   input  logic                       req_tlast,   // end_of_expr
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [((VALUE_WIDTH+pse_pkg::STATUS_W+7)/8)*8-1:0] rsp_tdata // value, status
);
   import pse_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pse_dp #(
      .STACK_DEPTH   (STACK_DEPTH),
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[VALUE_WIDTH +: STATUS_W] <= STATUS_SAT)
      else $error("status code out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("beat accepted while a character is in work");

   a_result_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result issued without a finished expression");

endmodule
